@@ design/abkf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types, constants and fixed-point helpers of the angle/bias filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

	localparam int DATA_W  = 32;
	localparam int DT_W    = 16;
	localparam int NOISE_W = 31;
	localparam int OPA_W   = 35;
	localparam int WIDE_W  = 68;
	localparam int DEN_W   = 34;
	localparam int ADDR_W  = 4;

	localparam logic [NOISE_W-1:0] QA_RESET = 31'd16777;
	localparam logic [NOISE_W-1:0] QB_RESET = 31'd50332;
	localparam logic [NOISE_W-1:0] R_RESET  = 31'd503317;

	localparam logic [1:0] REG_QA = 2'd0;
	localparam logic [1:0] REG_QB = 2'd1;
	localparam logic [1:0] REG_R  = 2'd2;

	localparam logic [5:0] MUL_STEPS_K  = 6'd32;
	localparam logic [5:0] MUL_STEPS_DT = 6'd16;
	localparam logic [5:0] DIV_STEPS    = 6'd56;

	localparam logic signed [WIDE_W-1:0] SAT_HI = 68'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -68'sd2147483648;
	localparam logic signed [WIDE_W-1:0] HALF16 = 68'sd32768;
	localparam logic signed [WIDE_W-1:0] HALF24 = 68'sd8388608;

	typedef struct packed {
		logic start;
		logic sgn;
	} mul_req_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [WIDE_W-1:0] v);
		return (v + HALF16) >>> 16;
	endfunction

	function automatic logic signed [WIDE_W-1:0] rnd24(input logic signed [WIDE_W-1:0] v);
		return (v + HALF24) >>> 24;
	endfunction

endpackage

@@ design/abkf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_if
// Request channels of the filter: sample in, estimate out.
// ----------------------------------------------------------------------------
interface abkf_sample_if import abkf_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] gyro_rate;
	logic signed [DATA_W-1:0] measured_angle;
	logic [DT_W-1:0]          time_step;

	modport source(output valid, gyro_rate, measured_angle, time_step, input ready);
	modport sink(input valid, gyro_rate, measured_angle, time_step, output ready);
endinterface

interface abkf_result_if import abkf_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] angle_estimate;
	logic signed [DATA_W-1:0] bias_estimate;
	logic signed [DATA_W-1:0] corrected_rate;

	modport source(output valid, angle_estimate, bias_estimate, corrected_rate, input ready);
	modport sink(input valid, angle_estimate, bias_estimate, corrected_rate, output ready);
endinterface

@@ design/abkf_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module abkf_mul import abkf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mul_req_t                 req,
	input  logic signed [OPA_W-1:0]  a,
	input  logic [DATA_W-1:0]        b,
	output logic signed [WIDE_W-1:0] prod,
	output logic                     done
);
	logic signed [WIDE_W-1:0] acc_q;
	logic signed [WIDE_W-1:0] mc_q;
	logic [DATA_W-1:0]        mb_q;
	logic [5:0]               cnt_q;
	logic                     busy_q;
	logic                     sgn_q;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.sgn ? MUL_STEPS_K : MUL_STEPS_DT;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= WIDE_W'(a);
			mb_q  <= b;
			sgn_q <= req.sgn;
		end else if (busy_q) begin
			if (mb_q[0]) begin
				if (sgn_q && cnt_q == 6'd1) begin
					acc_q <= acc_q - mc_q;
				end else begin
					acc_q <= acc_q + mc_q;
				end
			end
			mc_q <= mc_q <<< 1;
			mb_q <= mb_q >> 1;
		end
	end

	assign prod = acc_q;
	assign done = done_q;
endmodule

@@ design/abkf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_div
// Restoring divider for the gain: sat32((num * 2^24) / den), one bit a cycle.
// ----------------------------------------------------------------------------
module abkf_div import abkf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] num,
	input  logic signed [DEN_W-1:0]  den,
	output logic signed [DATA_W-1:0] quo,
	output logic                     done
);
	logic [55:0]              dq_q;
	logic [DEN_W-1:0]         rem_q;
	logic [DEN_W-1:0]         dm_q;
	logic                     neg_q;
	logic                     zero_q;
	logic [5:0]               cnt_q;
	logic                     busy_q;
	logic                     fin_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0]        nabs;
	logic [DEN_W-1:0]         dabs;
	logic [DEN_W-1:0]         r2;
	logic                     fit;

	assign nabs = num[DATA_W-1] ? (~num + 32'd1) : num;
	assign dabs = den[DEN_W-1] ? (~den + 34'd1) : den;
	assign r2   = {rem_q[DEN_W-2:0], dq_q[55]};
	assign fit  = (r2 >= dm_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= {nabs, 24'd0};
			rem_q  <= '0;
			dm_q   <= dabs;
			neg_q  <= num[DATA_W-1] ^ den[DEN_W-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= fit ? (r2 - dm_q) : r2;
			dq_q  <= {dq_q[54:0], fit};
		end
		if (fin_q) begin
			if (zero_q) begin
				quo_q <= '0;
			end else if (neg_q) begin
				quo_q <= (dq_q > 56'h80000000) ? 32'sh80000000 : (~dq_q[31:0] + 32'd1);
			end else begin
				quo_q <= (dq_q > 56'h7FFFFFFF) ? 32'sh7FFFFFFF : dq_q[31:0];
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

@@ design/angle_bias_kalman_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state (angle, gyro bias) Kalman filter in fixed point.
// ----------------------------------------------------------------------------
// One sample is processed at a time. The next sample can be taken in the cycle
// after the output step loads the result of the last one. The time goes to
// four 16-step multiplier passes, six 32-step multiplier passes and two
// 56-step passes through the restoring divider, plus the rate and output
// steps. A finished estimate waits in the output register while the next
// sample is accepted; the output step stalls only while an older estimate is
// still waiting there. Noise registers sit at byte addresses 0, 4 and 8 and
// keep their low 31 bits.
module angle_bias_kalman_filter import abkf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	abkf_sample_if.sink       sample,
	abkf_result_if.source     result
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;

	localparam logic [3:0] OP_RATE  = 4'd0;
	localparam logic [3:0] OP_ANG   = 4'd1;
	localparam logic [3:0] OP_DTP   = 4'd2;
	localparam logic [3:0] OP_N00   = 4'd3;
	localparam logic [3:0] OP_N11   = 4'd4;
	localparam logic [3:0] OP_K0    = 4'd5;
	localparam logic [3:0] OP_K1    = 4'd6;
	localparam logic [3:0] OP_ANGC  = 4'd7;
	localparam logic [3:0] OP_BIASC = 4'd8;
	localparam logic [3:0] OP_C00   = 4'd9;
	localparam logic [3:0] OP_C01   = 4'd10;
	localparam logic [3:0] OP_C10   = 4'd11;
	localparam logic [3:0] OP_C11   = 4'd12;
	localparam logic [3:0] OP_OUT   = 4'd13;

	logic [1:0]               state_q;
	logic [3:0]               step_q;
	logic                     wait_q;
	logic [NOISE_W-1:0]       qa_q, qb_q, r_q;
	logic signed [DATA_W-1:0] gyro_q, meas_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [DATA_W-1:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [DATA_W-1:0] rate_q, ang_q, n00_q, n01_q, n10_q, n11_q;
	logic signed [DATA_W-1:0] k0_q, k1_q, y_q;
	logic signed [OPA_W-1:0]  inner_q;
	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_ang_q, res_bias_q, res_rate_q;

	mul_req_t                 mul_req;
	logic signed [OPA_W-1:0]  mul_a;
	logic [DATA_W-1:0]        mul_b;
	logic signed [WIDE_W-1:0] prod;
	logic                     mul_done;
	logic                     is_div;
	logic                     div_start;
	logic signed [DATA_W-1:0] div_num;
	logic signed [DEN_W-1:0]  div_den;
	logic signed [DATA_W-1:0] quo;
	logic                     div_done;
	logic                     unit_done;
	logic signed [WIDE_W-1:0] p16, p24, dtp;
	logic                     cfg_wr;
	logic                     out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_QA:  prdata = {1'b0, qa_q};
			REG_QB:  prdata = {1'b0, qb_q};
			REG_R:   prdata = {1'b0, r_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= QA_RESET;
			qb_q <= QB_RESET;
			r_q  <= R_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_QA:  qa_q <= pwdata[NOISE_W-1:0];
				REG_QB:  qb_q <= pwdata[NOISE_W-1:0];
				REG_R:   r_q  <= pwdata[NOISE_W-1:0];
				default: ;
			endcase
		end
	end

	// operand select for the shared units
	always_comb begin
		mul_a  = 35'(rate_q);
		mul_b  = 32'(dt_q);
		is_div = 1'b0;
		case (step_q)
			OP_ANG:   mul_a = 35'(rate_q);
			OP_DTP:   mul_a = 35'(p11_q);
			OP_N00:   mul_a = inner_q;
			OP_N11:   mul_a = $signed({4'd0, qb_q});
			OP_K0:    is_div = 1'b1;
			OP_K1:    is_div = 1'b1;
			OP_ANGC:  begin mul_a = 35'(y_q);   mul_b = k0_q; end
			OP_BIASC: begin mul_a = 35'(y_q);   mul_b = k1_q; end
			OP_C00:   begin mul_a = 35'(n00_q); mul_b = k0_q; end
			OP_C01:   begin mul_a = 35'(n01_q); mul_b = k0_q; end
			OP_C10:   begin mul_a = 35'(n00_q); mul_b = k1_q; end
			OP_C11:   begin mul_a = 35'(n01_q); mul_b = k1_q; end
			default:  ;
		endcase
	end

	assign div_num = (step_q == OP_K1) ? n10_q : n00_q;
	assign div_den = DEN_W'(n00_q) + $signed({3'd0, r_q});

	assign mul_req.sgn   = (step_q >= OP_ANGC);
	assign mul_req.start = (state_q == ST_RUN) && !wait_q && !is_div &&
		(step_q != OP_RATE) && (step_q != OP_OUT);
	assign div_start     = (state_q == ST_RUN) && !wait_q && is_div;
	assign unit_done     = is_div ? div_done : mul_done;

	abkf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	abkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.done   (div_done)
	);

	assign p16 = rnd16(prod);
	assign p24 = rnd24(prod);
	assign dtp = p16;

	assign sample.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_RUN) && (step_q == OP_OUT) &&
		(!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= OP_RATE;
			wait_q      <= 1'b0;
			res_valid_q <= 1'b0;
			angle_q     <= '0;
			bias_q      <= '0;
			p00_q       <= '0;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= '0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						state_q <= ST_RUN;
						step_q  <= OP_RATE;
						wait_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (step_q == OP_RATE) begin
						step_q <= OP_ANG;
					end else if (step_q == OP_OUT) begin
						if (out_load) begin
							state_q <= ST_IDLE;
						end
					end else if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (unit_done) begin
						wait_q <= 1'b0;
						step_q <= step_q + 4'd1;
						case (step_q)
							OP_ANGC:  angle_q <= sat32(WIDE_W'(ang_q) + p24);
							OP_BIASC: bias_q  <= sat32(WIDE_W'(bias_q) + p24);
							OP_C00:   p00_q   <= sat32(WIDE_W'(n00_q) - p24);
							OP_C01:   p01_q   <= sat32(WIDE_W'(n01_q) - p24);
							OP_C10:   p10_q   <= sat32(WIDE_W'(n10_q) - p24);
							OP_C11:   p11_q   <= sat32(WIDE_W'(n11_q) - p24);
							default:  ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample.valid) begin
			gyro_q <= sample.gyro_rate;
			meas_q <= sample.measured_angle;
			dt_q   <= sample.time_step;
		end
		if (state_q == ST_RUN && step_q == OP_RATE) begin
			rate_q <= sat32(WIDE_W'(gyro_q) - WIDE_W'(bias_q));
		end
		if (state_q == ST_RUN && wait_q && unit_done) begin
			case (step_q)
				OP_ANG: begin
					ang_q <= sat32(WIDE_W'(angle_q) + p16);
				end
				OP_DTP: begin
					inner_q <= OPA_W'(dtp - WIDE_W'(p01_q) - WIDE_W'(p10_q) +
						$signed({37'd0, qa_q}));
					n01_q   <= sat32(WIDE_W'(p01_q) - dtp);
					n10_q   <= sat32(WIDE_W'(p10_q) - dtp);
				end
				OP_N00: n00_q <= sat32(WIDE_W'(p00_q) + p16);
				OP_N11: n11_q <= sat32(WIDE_W'(p11_q) + p16);
				OP_K0: begin
					k0_q <= quo;
					y_q  <= sat32(WIDE_W'(meas_q) - WIDE_W'(ang_q));
				end
				OP_K1:  k1_q <= quo;
				default: ;
			endcase
		end
		if (out_load) begin
			res_ang_q  <= angle_q;
			res_bias_q <= bias_q;
			res_rate_q <= rate_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.angle_estimate = res_ang_q;
	assign result.bias_estimate  = res_bias_q;
	assign result.corrected_rate = res_rate_q;

`ifndef SYNTHESIS
	a_out_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_RUN && step_q == OP_OUT))
		else $error("result raised outside the final step");
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_start))
		else $error("multiplier and divider started together");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> step_q <= OP_OUT)
		else $error("sequencer step out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> !sample.ready)
		else $error("sample request taken while a unit is busy");
`endif
endmodule

@@ dv/angle_bias_kalman_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_tb
// Feeds gyro/angle samples through the filter, writes the noise registers
// between phases and compares every estimate against a fixed-point predictor.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_tb;
	import abkf_pkg::*;

	typedef struct {
		logic signed [31:0] gyro;
		logic signed [31:0] meas;
		logic [15:0]        dt;
	} sample_t;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] bias;
		logic signed [31:0] rate;
	} estimate_t;

	localparam longint CYCLE_LIMIT = 2000000;
	localparam int     IDLE_WAIT   = 500;
	localparam int     LONG_HOLD   = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	abkf_sample_if sample_ch();
	abkf_result_if result_ch();

	angle_bias_kalman_filter uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample(sample_ch.sink), .result(result_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sample_t   pending_samples[$];
	estimate_t expected_estimates[$];
	int        errors = 0;
	int        cfg_errors = 0;
	longint    cycles = 0;
	int        hold_off = 0;
	bit        hold_go = 1'b0;
	bit        hold_fired = 1'b0;
	bit        hold_input = 1'b0;

	logic [30:0] q_angle, q_bias, r_meas;
	logic signed [31:0] st_angle, st_bias, c00, c01, c10, c11;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// Products of Q8.24 gains and 32-bit values fit in 64 bits.
	function automatic estimate_t filter_update(sample_t s);
		estimate_t e;
		longint gyro, meas, dt, rate, ang, dtp11, inner, n00, n01, n10, n11;
		longint den, k0, k1, y;
		gyro = s.gyro;
		meas = s.meas;
		dt = longint'(s.dt);
		rate = clamp32(gyro - st_bias);
		ang = clamp32(st_angle + round_shift(dt * rate, 16));
		dtp11 = round_shift(dt * c11, 16);
		inner = dtp11 - c01 - c10 + longint'(q_angle);
		n00 = clamp32(c00 + round_shift(dt * inner, 16));
		n01 = clamp32(c01 - dtp11);
		n10 = clamp32(c10 - dtp11);
		n11 = clamp32(c11 + round_shift(longint'(q_bias) * dt, 16));
		den = n00 + longint'(r_meas);
		k0 = 0;
		k1 = 0;
		if (den != 0) begin
			k0 = clamp32((n00 * 64'sd16777216) / den);
			k1 = clamp32((n10 * 64'sd16777216) / den);
		end
		y = clamp32(meas - ang);
		e.angle = 32'(clamp32(ang + round_shift(k0 * y, 24)));
		e.bias = 32'(clamp32(st_bias + round_shift(k1 * y, 24)));
		e.rate = 32'(rate);
		c00 = 32'(clamp32(n00 - round_shift(k0 * n00, 24)));
		c01 = 32'(clamp32(n01 - round_shift(k0 * n01, 24)));
		c10 = 32'(clamp32(n10 - round_shift(k1 * n00, 24)));
		c11 = 32'(clamp32(n11 - round_shift(k1 * n01, 24)));
		st_angle = e.angle;
		st_bias = e.bias;
		return e;
	endfunction

	// Driver: predict at acceptance, hold an offered sample until it is taken.
	int in_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (sample_ch.valid && sample_ch.ready) begin
			expected_estimates.push_back(filter_update(pending_samples.pop_front()));
			in_gap = $urandom_range(0, 3);
		end
		if (sample_ch.valid && !sample_ch.ready) begin
			sample_ch.valid <= 1'b1;
		end else if (in_gap > 0) begin
			in_gap = in_gap - 1;
			sample_ch.valid <= 1'b0;
		end else if (hold_input || pending_samples.size() == 0) begin
			sample_ch.valid <= 1'b0;
		end else begin
			sample_ch.valid <= 1'b1;
			sample_ch.gyro_rate <= pending_samples[0].gyro;
			sample_ch.measured_angle <= pending_samples[0].meas;
			sample_ch.time_step <= pending_samples[0].dt;
		end
	end

	// Long receiver stall, counted here once requested.
	always @(posedge clk) begin
		if (hold_go && !hold_fired) begin
			hold_off <= LONG_HOLD;
			hold_fired <= 1'b1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end
	end

	// Monitor: compare each estimate with the oldest prediction.
	int out_gap = 0;
	always @(posedge clk) begin
		estimate_t e;
		if (result_ch.valid && result_ch.ready) begin
			if (expected_estimates.size() == 0) begin
				$error("unexpected estimate angle=%0d", result_ch.angle_estimate);
				errors++;
			end else begin
				e = expected_estimates.pop_front();
				if (result_ch.angle_estimate !== e.angle) begin
					$error("angle_estimate expected %0d got %0d", e.angle,
					       result_ch.angle_estimate);
					errors++;
				end
				if (result_ch.bias_estimate !== e.bias) begin
					$error("bias_estimate expected %0d got %0d", e.bias,
					       result_ch.bias_estimate);
					errors++;
				end
				if (result_ch.corrected_rate !== e.rate) begin
					$error("corrected_rate expected %0d got %0d", e.rate,
					       result_ch.corrected_rate);
					errors++;
				end
			end
			out_gap = $urandom_range(0, 3);
		end
		if (hold_off > 0) begin
			result_ch.ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap = out_gap - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.gyro_rate = '0;
		sample_ch.measured_angle = '0;
		sample_ch.time_step = '0;
		result_ch.ready = 1'b0;
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (pready !== 1'b1) begin
			$error("pready expected 1 got %0b", pready);
			cfg_errors++;
		end
		if (prdata !== {1'b0, value[30:0]}) begin
			$error("prdata expected %0h got %0h", {1'b0, value[30:0]}, prdata);
			cfg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_QA: q_angle = value[30:0];
			REG_QB: q_bias = value[30:0];
			REG_R:  r_meas = value[30:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && expected_estimates.size() == 0);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'sh7FFFFFFF - $urandom_range(0, 3);
			2: return 32'sh80000000 + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
		endcase
	endfunction

	task automatic push_sample(logic signed [31:0] g, logic signed [31:0] m,
	                           logic [15:0] d);
		sample_t s;
		s.gyro = g;
		s.meas = m;
		s.dt = d;
		pending_samples.push_back(s);
	endtask

	task automatic random_samples(int n);
		logic [15:0] d;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: d = 16'($urandom);
				1: d = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
				default: d = 16'($urandom_range(1, 200));
			endcase
			push_sample(rand_word(), rand_word(), d);
		end
	endtask

	initial begin
		q_angle = QA_RESET;
		q_bias = QB_RESET;
		r_meas = R_RESET;
		st_angle = 0;
		st_bias = 0;
		c00 = 0;
		c01 = 0;
		c10 = 0;
		c11 = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// zero innovation variance: measurement noise zero, covariance zero, dt zero
		apb_write(REG_R, 32'h0);
		push_sample(32'sd65536, 32'sd131072, 16'h0000);
		push_sample(32'sh7FFFFFFF, 32'sh80000000, 16'h0000);
		drain();
		apb_write(REG_R, 32'hFFFFFFFF);
		apb_write(REG_QA, 32'hFFFFFFFF);
		apb_write(REG_QB, 32'hFFFFFFFF);
		push_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hFFFF);
		push_sample(32'sh80000000, 32'sh80000000, 16'hFFFF);
		push_sample(32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF);
		push_sample(32'sh7FFFFFFF, 32'sh80000000, 16'h0001);
		push_sample(32'sd0, 32'sd0, 16'h8000);
		push_sample(32'shFFFFFFFF, 32'sd1, 16'h7FFF);
		push_sample(32'sh55555555, 32'shAAAAAAAA, 16'h5555);
		push_sample(32'shAAAAAAAA, 32'sh55555555, 16'hAAAA);
		drain();
		apb_write(REG_QA, 32'h0);
		apb_write(REG_QB, 32'h0);
		apb_write(REG_R, 32'h1);
		random_samples(40);
		drain();
		apb_write(REG_QA, 32'(QA_RESET));
		apb_write(REG_QB, 32'(QB_RESET));
		apb_write(REG_R, 32'(R_RESET));
		random_samples(150);
		hold_go = 1'b1;
		random_samples(150);
		drain();
		apb_write(REG_QA, $urandom);
		apb_write(REG_QB, $urandom);
		apb_write(REG_R, $urandom);
		random_samples(60);
		hold_input = 1'b1;
		wait (expected_estimates.size() == 0 && sample_ch.valid == 1'b0);
		repeat (10) @(posedge clk);
		hold_input = 1'b0;
		random_samples(140);
		drain();

		if (errors == 0 && cfg_errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/abkf_pkg.sv
design/abkf_if.sv
design/abkf_mul.sv
design/abkf_div.sv
design/angle_bias_kalman_filter.sv
dv/angle_bias_kalman_filter_tb.sv
